### rtl/lfss_pkg.sv
// ----------------------------------------------------------------------------
// lfss_pkg
// Shared types and constants for the LED frame shift serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfss_pkg;

  // Frame word geometry
  localparam int unsigned WordW    = 16;
  localparam int unsigned BitSelW  = 4;
  // Wide enough for any LED number up to the largest supported count
  localparam int unsigned LedExtW  = 6;
  localparam int unsigned WordSelW = LedExtW - BitSelW;

  localparam logic [WordW-1:0] WordAllOnes = 16'hffff;

  // Input word operation codes
  typedef enum logic {
    OpWrite   = 1'b0,
    OpRefresh = 1'b1
  } op_e;

  // Controller states
  typedef enum logic {
    StIdle  = 1'b0,
    StShift = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic write_en;
    logic load_start;
    logic shift_en;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_bit;
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/lfss_ctrl.sv
// ----------------------------------------------------------------------------
// lfss_ctrl
// Controller: accepts input words and sequences the shift-out of a refresh.
// ----------------------------------------------------------------------------
`default_nettype none

module lfss_ctrl import lfss_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    op_i,
  input  status_t      status_i,
  output logic         in_ready_o,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  // Take a word only between refreshes
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && (op_i == OpRefresh)) begin
          state_d = StShift;
        end
      end
      StShift: begin
        if (status_i.slot_free && status_i.last_bit) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        cmd_o.write_en   = accept && (op_i == OpWrite);
        cmd_o.load_start = accept && (op_i == OpRefresh);
      end
      StShift: begin
        cmd_o.shift_en = status_i.slot_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/lfss_datapath.sv
// ----------------------------------------------------------------------------
// lfss_datapath
// Datapath: frame store, LED bit counter and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfss_datapath import lfss_pkg::*; #(
  parameter int unsigned LED_COUNT   = 32,
  parameter int unsigned FRAME_WORDS = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cmd_t                  cmd_i,
  input  wire logic             word_index_i,
  input  wire logic [WordW-1:0] word_data_i,
  input  wire logic             out_ready_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  output logic                  serial_level_o,
  output logic                  latch_after_o
);

  localparam int unsigned LedW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned WordAw = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

  logic [WordW-1:0]   store_q [FRAME_WORDS];
  logic [LedW-1:0]    led_q, led_d;
  logic [LedExtW-1:0] led_ext;
  logic [WordSelW-1:0] word_sel;
  logic               word_hit;
  logic [WordW-1:0]   word_rd;
  logic               led_lit;
  logic               out_valid_q, out_valid_d;
  logic               serial_q, serial_d;
  logic               latch_q, latch_d;
  logic               write_hit;

  // Split the LED number into word and bit select
  assign led_ext  = LedExtW'(led_q);
  assign word_sel = led_ext[LedExtW-1:BitSelW];
  assign word_hit = (32'(word_sel) < FRAME_WORDS);
  assign word_rd  = word_hit ? store_q[word_sel[WordAw-1:0]] : '0;
  assign led_lit  = word_rd[led_ext[BitSelW-1:0]];

  // Drop writes beyond the store
  assign write_hit = cmd_i.write_en && (32'(word_index_i) < FRAME_WORDS);

  // Frame store, all ones out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_WORDS; i++) begin
        store_q[i] <= WordAllOnes;
      end
    end else if (write_hit) begin
      store_q[WordAw'(word_index_i)] <= word_data_i;
    end
  end

  // Advance the LED counter from the top LED down
  always_comb begin
    led_d = led_q;
    if (cmd_i.load_start) begin
      led_d = LedW'(LED_COUNT - 1);
    end else if (cmd_i.shift_en) begin
      led_d = led_q - 1'b1;
    end
  end

  // Output word register: load the inverted LED bit, hold while stalled
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    serial_d    = serial_q;
    latch_d     = latch_q;
    if (cmd_i.shift_en) begin
      out_valid_d = 1'b1;
      serial_d    = ~led_lit;
      latch_d     = (led_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    serial_q <= serial_d;
    latch_q  <= latch_d;
  end

  assign status_o.last_bit  = (led_q == '0);
  assign status_o.slot_free = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign serial_level_o = serial_q;
  assign latch_after_o  = latch_q;

endmodule

`default_nettype wire

### rtl/led_frame_shift_serializer_unit.sv
// ----------------------------------------------------------------------------
// led_frame_shift_serializer_unit
// Serialises a frame of LED bits MSB first, one data pin level per word.
// ----------------------------------------------------------------------------
// Write word: gives no result; the next word is taken at once.
// Refresh word: the LED counter loads the top LED on acceptance, then one bit per
// cycle while the output side is not stalled, LED_COUNT results; the next word
// is taken once the last bit has entered the output register.
// Reset: frame store loads all ones, controller idle, output empty.
`default_nettype none

module led_frame_shift_serializer_unit import lfss_pkg::*; #(
  parameter int unsigned LED_COUNT   = 32,
  parameter int unsigned FRAME_WORDS = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             op_i,
  input  wire logic             word_index_i,
  input  wire logic [WordW-1:0] word_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  serial_level_o,
  output logic                  latch_after_o
);

  cmd_t    cmd;
  status_t status;

  // Sequence the refresh
  lfss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Hold the frame and shift bits out
  lfss_datapath #(
    .LED_COUNT   (LED_COUNT),
    .FRAME_WORDS (FRAME_WORDS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .word_index_i   (word_index_i),
    .word_data_i    (word_data_i),
    .out_ready_i    (out_ready_i),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .serial_level_o (serial_level_o),
    .latch_after_o  (latch_after_o)
  );

endmodule

`default_nettype wire
